// File: hdl/srcc_pkg.sv
// Shared types, constants and helpers for the disc-to-equirectangular remap unit.
package srcc_pkg;

    localparam int MAX_DISC_SIZE = 4096;
    localparam int MAX_SRC_WIDTH = 8192;
    localparam int MAX_SRC_ROWS  = 4096;
    localparam int ANGLE_BITS    = 16;
    localparam int FRAC_BITS     = 16;

    localparam int CORDIC_STAGES = 32;
    localparam int SQRT_STAGES   = 21;
    localparam int POST_STAGES   = 3;
    // front stages: operand/square stage, sum/prep stage; one lat prep stage after sqrt
    localparam int NUM_STAGES    = 2 + SQRT_STAGES + 1 + CORDIC_STAGES + POST_STAGES;
    localparam int LON_DELAY     = SQRT_STAGES + 1;
    localparam int TAG_DELAY     = NUM_STAGES - 2;
    localparam int CW            = 44;

    localparam logic [2:0] CFG_DISC_SIZE    = 3'd0;
    localparam logic [2:0] CFG_LON_OFFSET   = 3'd1;
    localparam logic [2:0] CFG_SRC_WIDTH    = 3'd2;
    localparam logic [2:0] CFG_SRC_HEIGHT   = 3'd3;
    localparam logic [2:0] CFG_SOUTH_HALF   = 3'd4;
    localparam logic [2:0] CFG_MIRROR_SOUTH = 3'd5;

    localparam logic [31:0] TURN_HALF    = 32'h8000_0000;
    localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;
    localparam logic [31:0] TURN_3QTR    = 32'hC000_0000;
    localparam logic [31:0] TURN_EIGHTH  = 32'h2000_0000;
    localparam logic [31:0] ANG_HALF     = 32'(1) << (31 - ANGLE_BITS);
    localparam logic [31:0] ANG_MASK     = ~((32'(1) << (32 - ANGLE_BITS)) - 32'(1));

    localparam logic [31:0] CORDIC_TAB [CORDIC_STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic [11:0] pixel_col;
        logic [11:0] pixel_row;
    } t_in;

    typedef struct packed {
        logic        inside_disc;
        logic [11:0] dest_col;
        logic [11:0] dest_row;
        logic [12:0] src_col_left;
        logic [12:0] src_col_right;
        logic [11:0] src_row_top;
        logic [11:0] src_row_bottom;
        logic [15:0] frac_col;
        logic [15:0] frac_row;
    } t_out;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [31:0]          z;
    } t_cordic;

    typedef struct packed {
        logic [41:0] v;
        logic [24:0] rem;
        logic [20:0] root;
    } t_sqrt;

    typedef struct packed {
        logic        in_disc;
        logic [11:0] dest_col;
        logic [11:0] dest_row;
    } t_tag;

    typedef struct packed {
        logic [15:0] lon_offset;
        logic [13:0] width;
        logic [12:0] height;
        logic        south;
    } t_post_cfg;

    typedef struct packed {
        logic [12:0] col_left;
        logic [12:0] col_right;
        logic [11:0] row_top;
        logic [11:0] row_bottom;
        logic [15:0] frac_col;
        logic [15:0] frac_row;
    } t_post;

    function automatic logic [31:0] round_angle(input logic [31:0] v);
        return (v + ANG_HALF) & ANG_MASK;
    endfunction

    function automatic logic [15:0] to_q16(input logic [31:0] f);
        logic [31:0] g;
        if (FRAC_BITS <= 16) g = f << (16 - FRAC_BITS);
        else g = f >> (FRAC_BITS - 16);
        return (g > 32'd65535) ? 16'hFFFF : g[15:0];
    endfunction

endpackage

// File: hdl/srcc_cordic_stage.sv
// One registered CORDIC vectoring iteration in 32-bit turns.
module srcc_cordic_stage (
    input  logic              i_clk,
    input  logic              i_ce,
    input  logic [4:0]        i_idx,
    input  srcc_pkg::t_cordic i_st,
    output srcc_pkg::t_cordic o_st
);
    import srcc_pkg::*;

    t_cordic          r_st;
    t_cordic          n_st;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    always_comb begin
        dx = i_st.y >>> i_idx;
        dy = i_st.x >>> i_idx;
        if ($signed(i_st.y) > $signed(CW'(0))) begin
            n_st.x = i_st.x + dx;
            n_st.y = i_st.y - dy;
            n_st.z = i_st.z + CORDIC_TAB[i_idx];
        end else begin
            n_st.x = i_st.x - dx;
            n_st.y = i_st.y + dy;
            n_st.z = i_st.z - CORDIC_TAB[i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) r_st <= n_st;
    end

    assign o_st = r_st;
endmodule

// File: hdl/srcc_sqrt_stage.sv
// One registered digit of a restoring integer square root, two radicand bits a step.
module srcc_sqrt_stage (
    input  logic            i_clk,
    input  logic            i_ce,
    input  srcc_pkg::t_sqrt i_st,
    output srcc_pkg::t_sqrt o_st
);
    import srcc_pkg::*;

    t_sqrt       r_st;
    t_sqrt       n_st;
    logic [24:0] rem2;
    logic [24:0] trial;

    always_comb begin
        rem2   = {i_st.rem[22:0], i_st.v[41:40]};
        trial  = {2'b00, i_st.root, 2'b01};
        n_st.v = {i_st.v[39:0], 2'b00};
        if (rem2 >= trial) begin
            n_st.rem  = rem2 - trial;
            n_st.root = {i_st.root[19:0], 1'b1};
        end else begin
            n_st.rem  = rem2;
            n_st.root = {i_st.root[19:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) r_st <= n_st;
    end

    assign o_st = r_st;
endmodule

// File: hdl/srcc_post.sv
// Angle rounding, scaling to source pixels, wrap/clamp and weight extraction (3 stages).
module srcc_post (
    input  logic                i_clk,
    input  logic                i_ce,
    input  logic [31:0]         i_lon,
    input  logic [31:0]         i_phi,
    input  srcc_pkg::t_post_cfg i_cfg,
    output srcc_pkg::t_post     o_post
);
    import srcc_pkg::*;

    logic [31:0] n_u, n_d, lon_r, phi_c, lat;
    logic [31:0] r_u, r_d;
    logic [45:0] r_xm;
    logic [44:0] r_ym;
    logic [45:0] xsh;
    logic [44:0] ysh;
    logic [13:0] x0w, x0, x1p, y0w;
    logic [12:0] y0, y1;
    logic [12:0] hm1;
    logic [29:0] yf;
    t_post       n_post;
    t_post       r_post;

    // stage 1: round both angles, shift longitude by offset and half a turn
    always_comb begin
        lon_r = round_angle(i_lon - {i_cfg.lon_offset, 16'h0000});
        n_u   = lon_r + TURN_HALF;
        phi_c = (i_phi > TURN_EIGHTH) ? TURN_EIGHTH : i_phi;
        lat   = round_angle(TURN_QUARTER - {phi_c[30:0], 1'b0});
        n_d   = i_cfg.south ? (TURN_QUARTER + lat) : (TURN_QUARTER - lat);
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_u  <= n_u;
            r_d  <= n_d;
            r_xm <= 46'(r_u) * 46'(i_cfg.width);
            r_ym <= 45'(r_d) * 45'(i_cfg.height);
            r_post <= n_post;
        end
    end

    // stage 3: split into integer pixel and fraction, wrap columns, clamp rows
    always_comb begin
        xsh = r_xm >> (32 - FRAC_BITS);
        ysh = r_ym >> (31 - FRAC_BITS);
        x0w = 14'(xsh >> FRAC_BITS);
        x0  = (x0w > i_cfg.width - 14'd1) ? (i_cfg.width - 14'd1) : x0w;
        x1p = x0 + 14'd1;
        hm1 = i_cfg.height - 13'd1;
        y0w = 14'(ysh >> FRAC_BITS);
        y0  = (y0w > {1'b0, hm1}) ? hm1 : y0w[12:0];
        y1  = (y0 + 13'd1 > hm1) ? hm1 : (y0 + 13'd1);
        yf  = 30'(ysh) - 30'({y0, 16'h0000} >> (16 - FRAC_BITS));
        n_post.col_left   = x0[12:0];
        n_post.col_right  = (x1p >= i_cfg.width) ? 13'd0 : x1p[12:0];
        n_post.row_top    = y0[11:0];
        n_post.row_bottom = y1[11:0];
        n_post.frac_col   = to_q16(32'(xsh & ((46'(1) << FRAC_BITS) - 46'(1))));
        n_post.frac_row   = to_q16(32'(yf));
    end

    assign o_post = r_post;
endmodule

// File: hdl/stereo_disc_remap_coords_unit.sv
// Accepts one request per cycle while the skid register is empty.
// The depth is set by the 21-step square root followed by the 32-step latitude CORDIC.
// A skid register behind the output register lets one request enter while a result waits.
// Reset (synchronous, active low) clears all valid bits and loads the register defaults.
// Configuration writes are taken every cycle.
module stereo_disc_remap_coords_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  srcc_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output srcc_pkg::t_out  o_out_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [2:0]      i_cfg_index,
    input  logic [15:0]     i_cfg_data
);
    import srcc_pkg::*;

    logic [12:0] r_disc_size, r_src_height;
    logic [15:0] r_lon_offset;
    logic [13:0] r_src_width;
    logic        r_south_half, r_mirror_south;
    logic [12:0] s_eff, h_eff;
    logic [13:0] w_eff;
    logic        ce;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disc_size    <= 13'd2048;
            r_lon_offset   <= 16'd0;
            r_src_width    <= 14'd2048;
            r_src_height   <= 13'd1024;
            r_south_half   <= 1'b0;
            r_mirror_south <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DISC_SIZE:    r_disc_size    <= i_cfg_data[12:0];
                CFG_LON_OFFSET:   r_lon_offset   <= i_cfg_data;
                CFG_SRC_WIDTH:    r_src_width    <= i_cfg_data[13:0];
                CFG_SRC_HEIGHT:   r_src_height   <= i_cfg_data[12:0];
                CFG_SOUTH_HALF:   r_south_half   <= i_cfg_data[0];
                CFG_MIRROR_SOUTH: r_mirror_south <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        s_eff = (r_disc_size > 13'(MAX_DISC_SIZE)) ? 13'(MAX_DISC_SIZE) : r_disc_size;
        if (r_src_width == 14'd0) w_eff = 14'd1;
        else if (r_src_width > 14'(MAX_SRC_WIDTH)) w_eff = 14'(MAX_SRC_WIDTH);
        else w_eff = r_src_width;
        if (r_src_height == 13'd0) h_eff = 13'd1;
        else if (r_src_height > 13'(MAX_SRC_ROWS)) h_eff = 13'(MAX_SRC_ROWS);
        else h_eff = r_src_height;
    end

    // ---------------- stage 1: centered operands and squares
    logic signed [14:0] n_a, n_b, r1_a, r1_b;
    logic signed [29:0] sqa, sqb;
    logic [25:0] r1_sqa, r1_sqb, s2;
    logic [24:0] r1_s2;
    logic        n_ok, r1_ok;
    t_tag        n_tag1, r1_tag;

    always_comb begin
        n_a  = $signed({2'b00, i_in_data.pixel_col, 1'b0}) - $signed({2'b00, s_eff});
        n_b  = $signed({2'b00, s_eff}) - $signed({2'b00, i_in_data.pixel_row, 1'b0});
        sqa  = n_a * n_a;
        sqb  = n_b * n_b;
        s2   = s_eff * s_eff;
        n_ok = (s_eff != 13'd0) && ({1'b0, i_in_data.pixel_col} < s_eff)
            && ({1'b0, i_in_data.pixel_row} < s_eff);
        n_tag1.in_disc  = 1'b0;
        n_tag1.dest_col = (r_south_half && r_mirror_south
            && ({1'b0, i_in_data.pixel_col} < s_eff))
            ? 12'(s_eff - 13'd1 - {1'b0, i_in_data.pixel_col}) : i_in_data.pixel_col;
        n_tag1.dest_row = i_in_data.pixel_row;
    end

    // ---------------- stage 2: radius test, CORDIC and root seeds
    logic [26:0] q;
    t_cordic     n_lon0, r2_lon;
    logic        n_lsp, r2_lsp;
    logic [31:0] n_lspz, r2_lspz;
    t_sqrt       r2_sq;
    t_tag        r2_tag;
    logic signed [CW-1:0] ax, by;

    always_comb begin
        q      = {1'b0, r1_sqa} + {1'b0, r1_sqb};
        ax     = CW'(r1_a);
        by     = CW'(r1_b);
        n_lsp  = 1'b0;
        n_lspz = 32'd0;
        n_lon0.z = 32'd0;
        n_lon0.x = ax;
        n_lon0.y = by;
        if (r1_b == 15'sd0) begin
            n_lsp  = 1'b1;
            n_lspz = (r1_a < 15'sd0) ? TURN_HALF : 32'd0;
        end else if (r1_a == 15'sd0) begin
            n_lsp  = 1'b1;
            n_lspz = (r1_b > 15'sd0) ? TURN_QUARTER : TURN_3QTR;
        end else if (r1_a < 15'sd0) begin
            // fold into the right half plane
            n_lon0.x = -ax;
            n_lon0.y = -by;
            n_lon0.z = TURN_HALF;
        end
        n_lon0.x = n_lon0.x <<< 20;
        n_lon0.y = n_lon0.y <<< 20;
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r1_a    <= n_a;
            r1_b    <= n_b;
            r1_sqa  <= sqa[25:0];
            r1_sqb  <= sqb[25:0];
            r1_s2   <= s2[24:0];
            r1_ok   <= n_ok;
            r1_tag  <= n_tag1;
            r2_lon  <= n_lon0;
            r2_lsp  <= n_lsp;
            r2_lspz <= n_lspz;
            r2_sq.v    <= {1'b0, q[24:0], 16'h0000};
            r2_sq.rem  <= 25'd0;
            r2_sq.root <= 21'd0;
            r2_tag.in_disc  <= r1_ok && (q <= {2'b00, r1_s2});
            r2_tag.dest_col <= r1_tag.dest_col;
            r2_tag.dest_row <= r1_tag.dest_row;
        end
    end

    // ---------------- longitude and latitude CORDICs, square root
    t_cordic lon_st [CORDIC_STAGES+1];
    t_cordic lat_st [CORDIC_STAGES+1];
    t_sqrt   sq_st  [SQRT_STAGES+1];
    assign lon_st[0] = r2_lon;
    assign sq_st[0]  = r2_sq;

    genvar k;
    generate
        for (k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
            srcc_cordic_stage u_lon (
                .i_clk (i_clk), .i_ce (ce), .i_idx (5'(k)),
                .i_st (lon_st[k]), .o_st (lon_st[k+1])
            );
            srcc_cordic_stage u_lat (
                .i_clk (i_clk), .i_ce (ce), .i_idx (5'(k)),
                .i_st (lat_st[k]), .o_st (lat_st[k+1])
            );
        end
        for (k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
            srcc_sqrt_stage u_sq (
                .i_clk (i_clk), .i_ce (ce), .i_st (sq_st[k]), .o_st (sq_st[k+1])
            );
        end
    endgenerate

    logic        r_lsp_dly  [CORDIC_STAGES];
    logic [31:0] r_lspz_dly [CORDIC_STAGES];
    logic        r_tsp_dly  [CORDIC_STAGES];
    logic [31:0] r_lonz_dly [LON_DELAY];
    t_tag        r_tag_dly  [TAG_DELAY];
    t_cordic     r_lat0;
    logic        r_lat_sp;
    logic [31:0] lon_final, phi;

    assign lon_final = r_lsp_dly[CORDIC_STAGES-1] ? r_lspz_dly[CORDIC_STAGES-1]
                                                  : lon_st[CORDIC_STAGES].z;
    assign lat_st[0] = r_lat0;
    assign phi = r_tsp_dly[CORDIC_STAGES-1] ? 32'd0 : lat_st[CORDIC_STAGES].z;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_lsp_dly[0]  <= r2_lsp;
            r_lspz_dly[0] <= r2_lspz;
            r_tsp_dly[0]  <= r_lat_sp;
            for (int i = 1; i < CORDIC_STAGES; i++) begin
                r_lsp_dly[i]  <= r_lsp_dly[i-1];
                r_lspz_dly[i] <= r_lspz_dly[i-1];
                r_tsp_dly[i]  <= r_tsp_dly[i-1];
            end
            r_lonz_dly[0] <= lon_final;
            for (int i = 1; i < LON_DELAY; i++) r_lonz_dly[i] <= r_lonz_dly[i-1];
            r_tag_dly[0] <= r2_tag;
            for (int i = 1; i < TAG_DELAY; i++) r_tag_dly[i] <= r_tag_dly[i-1];
            // latitude seed: atan2(root, S * 256), both scaled by 2^20
            r_lat0.x <= $signed({3'b000, s_eff, 28'h0000000});
            r_lat0.y <= $signed({3'b000, sq_st[SQRT_STAGES].root, 20'h00000});
            r_lat0.z <= 32'd0;
            r_lat_sp <= (sq_st[SQRT_STAGES].root == 21'd0);
        end
    end

    // ---------------- post processing
    t_post_cfg pcfg;
    t_post     post;
    assign pcfg.lon_offset = r_lon_offset;
    assign pcfg.width      = w_eff;
    assign pcfg.height     = h_eff;
    assign pcfg.south      = r_south_half;

    srcc_post u_post (
        .i_clk (i_clk), .i_ce (ce), .i_lon (r_lonz_dly[LON_DELAY-1]), .i_phi (phi),
        .i_cfg (pcfg), .o_post (post)
    );

    // ---------------- valid bits, output register and skid
    logic [NUM_STAGES-1:0] r_vld;
    logic  r_out_vld, r_skid_vld, out_take, tail_vld;
    t_out  tail, r_out, r_skid;
    t_tag  ttag;

    assign ce         = ~r_skid_vld;
    assign o_in_ready = ce;
    assign out_take   = r_out_vld & i_out_ready;
    assign tail_vld   = r_vld[NUM_STAGES-1];
    assign ttag       = r_tag_dly[TAG_DELAY-1];

    always_comb begin
        tail.inside_disc    = ttag.in_disc;
        tail.dest_col       = ttag.dest_col;
        tail.dest_row       = ttag.dest_row;
        tail.src_col_left   = ttag.in_disc ? post.col_left   : 13'd0;
        tail.src_col_right  = ttag.in_disc ? post.col_right  : 13'd0;
        tail.src_row_top    = ttag.in_disc ? post.row_top    : 12'd0;
        tail.src_row_bottom = ttag.in_disc ? post.row_bottom : 12'd0;
        tail.frac_col       = ttag.in_disc ? post.frac_col   : 16'd0;
        tail.frac_row       = ttag.in_disc ? post.frac_row   : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (ce) r_vld <= {r_vld[NUM_STAGES-2:0], i_in_valid};
            if (r_skid_vld) begin
                if (out_take) r_skid_vld <= 1'b0;
            end else if (tail_vld) begin
                if (!r_out_vld || out_take) r_out_vld <= 1'b1;
                else r_skid_vld <= 1'b1;
            end else if (out_take) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (out_take) r_out <= r_skid;
        end else if (tail_vld) begin
            // load the new result, or hold the waiting one and park the new one
            if (!r_out_vld || out_take) r_out <= tail;
            else r_skid <= tail;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
endmodule

// File: verif/stereo_disc_remap_coords_unit_tb.sv
// Self-checking testbench for the disc-to-equirectangular remap coordinate unit.
module stereo_disc_remap_coords_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import srcc_pkg::*;

    localparam logic [2:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [2:0] CFG_UNUSED_HI = 3'd7;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 70;
    localparam int HOLD_CYCLES = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in         i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    // shadow copy of the register file
    logic [12:0] sh_disc;
    logic [15:0] sh_lon_off;
    logic [13:0] sh_width;
    logic [12:0] sh_height;
    logic        sh_south;
    logic        sh_mirror;

    t_out remap_expected[$];
    int   error_count = 0;
    int   stall_cycles = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    bit   hold_request = 1'b0;
    int   hold_left = 0;

    stereo_disc_remap_coords_unit u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] cordic_turns(longint y, longint x);
        logic [31:0] z;
        longint dx, dy;
        z = '0;
        if (y == 0) return (x < 0) ? TURN_HALF : 32'h0;
        if (x == 0) return (y > 0) ? TURN_QUARTER : TURN_3QTR;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = TURN_HALF;
        end
        x = x * (64'sd1 << 20);
        y = y * (64'sd1 << 20);
        for (int i = 0; i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += CORDIC_TAB[i];
            end else begin
                x -= dx; y += dy; z -= CORDIC_TAB[i];
            end
        end
        return z;
    endfunction

    function automatic logic [31:0] round_turns(logic [31:0] v);
        return (v + 32'h0000_8000) & 32'hFFFF_0000;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic t_out predict_remap(t_in px);
        t_out res;
        longint unsigned s, w, h, q, xfp, yfp, x0, x1, y0, y1, d, col, row, fr;
        longint a, b;
        logic [31:0] lon, phi, lat, t;
        res = '0;
        col = px.pixel_col;
        row = px.pixel_row;
        s = (sh_disc > 13'd4096) ? 4096 : sh_disc;
        res.dest_col = (sh_south && sh_mirror && col < s) ? 12'(s - 1 - col) : px.pixel_col;
        res.dest_row = px.pixel_row;
        if (s == 0 || col >= s || row >= s) return res;
        a = 2 * longint'(col) - longint'(s);
        b = longint'(s) - 2 * longint'(row);
        q = longint'(a * a + b * b);
        if (q > s * s) return res;
        res.inside_disc = 1'b1;
        w = (sh_width == 0) ? 1 : (sh_width > 14'd8192) ? 8192 : sh_width;
        h = (sh_height == 0) ? 1 : (sh_height > 13'd4096) ? 4096 : sh_height;

        lon = round_turns(cordic_turns(b, a) - {sh_lon_off, 16'h0});
        t = lon + TURN_HALF;
        xfp = (longint'(t) * w) >> 16;
        x0 = xfp >> 16;
        if (x0 > w - 1) x0 = w - 1;
        x1 = (x0 + 1 >= w) ? 0 : x0 + 1;

        phi = cordic_turns(longint'(int_sqrt(q << 16)), longint'(s << 8));
        if (phi > TURN_EIGHTH) phi = TURN_EIGHTH;
        lat = round_turns(TURN_QUARTER - 2 * phi);
        d = sh_south ? 64'h4000_0000 + lat : 64'h4000_0000 - lat;
        yfp = (d * h) >> 15;
        y0 = yfp >> 16;
        if (y0 > h - 1) y0 = h - 1;
        y1 = (y0 + 1 > h - 1) ? h - 1 : y0 + 1;

        res.src_col_left   = 13'(x0);
        res.src_col_right  = 13'(x1);
        res.src_row_top    = 12'(y0);
        res.src_row_bottom = 12'(y1);
        res.frac_col       = xfp[15:0];
        fr = yfp - (y0 << 16);
        res.frac_row       = (fr > 65535) ? 16'hFFFF : 16'(fr);
        return res;
    endfunction

    // receiver: random stalls plus a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // predict on accepted requests, check accepted results, watch for stalls
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) remap_expected.push_back(predict_remap(i_in_data));
            if (o_out_valid && i_out_ready) begin
                if (remap_expected.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, o_out_data);
                    error_count++;
                end else begin
                    exp_r = remap_expected.pop_front();
                    if (exp_r.inside_disc !== o_out_data.inside_disc)
                        $display("%0t: inside_disc exp %0d got %0d", $time,
                                 exp_r.inside_disc, o_out_data.inside_disc);
                    if (exp_r.dest_col !== o_out_data.dest_col)
                        $display("%0t: dest_col exp %0d got %0d", $time,
                                 exp_r.dest_col, o_out_data.dest_col);
                    if (exp_r.dest_row !== o_out_data.dest_row)
                        $display("%0t: dest_row exp %0d got %0d", $time,
                                 exp_r.dest_row, o_out_data.dest_row);
                    if (exp_r.src_col_left !== o_out_data.src_col_left)
                        $display("%0t: src_col_left exp %0d got %0d", $time,
                                 exp_r.src_col_left, o_out_data.src_col_left);
                    if (exp_r.src_col_right !== o_out_data.src_col_right)
                        $display("%0t: src_col_right exp %0d got %0d", $time,
                                 exp_r.src_col_right, o_out_data.src_col_right);
                    if (exp_r.src_row_top !== o_out_data.src_row_top)
                        $display("%0t: src_row_top exp %0d got %0d", $time,
                                 exp_r.src_row_top, o_out_data.src_row_top);
                    if (exp_r.src_row_bottom !== o_out_data.src_row_bottom)
                        $display("%0t: src_row_bottom exp %0d got %0d", $time,
                                 exp_r.src_row_bottom, o_out_data.src_row_bottom);
                    if (exp_r.frac_col !== o_out_data.frac_col)
                        $display("%0t: frac_col exp %0d got %0d", $time,
                                 exp_r.frac_col, o_out_data.frac_col);
                    if (exp_r.frac_row !== o_out_data.frac_row)
                        $display("%0t: frac_row exp %0d got %0d", $time,
                                 exp_r.frac_row, o_out_data.frac_row);
                    if (exp_r !== o_out_data) error_count++;
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("Testbench completed WITH ERRORS");
                    $finish;
                end
            end
        end
    end

    // Called in the time step of the previous acceptance, so valid stays up back to back.
    task automatic send_pixel(logic [11:0] col, logic [11:0] row);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= '{pixel_col: col, pixel_row: row};
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        // let the checker log the last accepted request first
        @(posedge i_clk);
        while (remap_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_DISC_SIZE:    sh_disc = data[12:0];
            CFG_LON_OFFSET:   sh_lon_off = data;
            CFG_SRC_WIDTH:    sh_width = data[13:0];
            CFG_SRC_HEIGHT:   sh_height = data[12:0];
            CFG_SOUTH_HALF:   sh_south = data[0];
            CFG_MIRROR_SOUTH: sh_mirror = data[0];
            default: ;
        endcase
    endtask

    task automatic test_reset_defaults();
        send_pixel(12'd1024, 12'd1024);   // centre
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd1024, 12'd0);      // top of rim
        send_pixel(12'd0, 12'd1024);      // left of rim
        send_pixel(12'd2047, 12'd1024);
        send_pixel(12'd1500, 12'd300);
    endtask

    task automatic test_special_cases();
        write_reg(CFG_SOUTH_HALF, 16'd1);
        send_pixel(12'd1024, 12'd1024);   // south pole row saturates
        send_pixel(12'd10, 12'd1024);     // mirrored column
        send_pixel(12'd3000, 12'd5);      // outside, no mirror
        write_reg(CFG_MIRROR_SOUTH, 16'd0);
        send_pixel(12'd10, 12'd1024);
        write_reg(CFG_DISC_SIZE, 16'd0);
        send_pixel(12'd0, 12'd0);
        write_reg(CFG_DISC_SIZE, 16'd1);
        send_pixel(12'd0, 12'd0);
        write_reg(CFG_DISC_SIZE, 16'hFFFF);  // saturates to max size
        write_reg(CFG_SRC_WIDTH, 16'd0);
        write_reg(CFG_SRC_HEIGHT, 16'd0);
        write_reg(CFG_LON_OFFSET, 16'hFFFF);
        send_pixel(12'd2048, 12'd2048);
        send_pixel(12'd4095, 12'd2048);
        write_reg(CFG_SRC_WIDTH, 16'hFFFF);
        write_reg(CFG_SRC_HEIGHT, 16'hFFFF);
        write_reg(CFG_MIRROR_SOUTH, 16'd1);
        send_pixel(12'd0, 12'd2048);
        send_pixel(12'd2048, 12'd0);
        write_reg(CFG_UNUSED_LO, 16'h1234);
        write_reg(CFG_UNUSED_HI, 16'hFFFF);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd1234, 12'd3210);
    endtask

    task automatic randomize_config();
        logic [15:0] v;
        case ($urandom_range(5))
            0: v = 16'($urandom_range(1, 8));
            1: v = 16'd4096;
            2: v = 16'($urandom);
            default: v = 16'($urandom_range(1, 4096));
        endcase
        write_reg(CFG_DISC_SIZE, v);
        write_reg(CFG_LON_OFFSET, 16'($urandom));
        case ($urandom_range(3))
            0: v = 16'($urandom_range(0, 3));
            1: v = 16'd8192;
            2: v = 16'($urandom);
            default: v = 16'($urandom_range(1, 8192));
        endcase
        write_reg(CFG_SRC_WIDTH, v);
        case ($urandom_range(3))
            0: v = 16'($urandom_range(0, 3));
            1: v = 16'd4096;
            2: v = 16'($urandom);
            default: v = 16'($urandom_range(1, 4096));
        endcase
        write_reg(CFG_SRC_HEIGHT, v);
        write_reg(CFG_SOUTH_HALF, 16'($urandom));
        write_reg(CFG_MIRROR_SOUTH, 16'($urandom));
    endtask

    task automatic test_random_sweep(int send_pct, int recv_pct, int n_items);
        int s;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < n_items; i++) begin
            if (i % 80 == 0) randomize_config();
            s = (sh_disc > 13'd4096) ? 4096 : sh_disc;
            // mostly pixels on the disc image, some anywhere
            if (s > 0 && $urandom_range(99) < 85)
                send_pixel(12'($urandom_range(0, s - 1)), 12'($urandom_range(0, s - 1)));
            else
                send_pixel(12'($urandom), 12'($urandom));
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1'b1;
        for (int i = 0; i < 150; i++) send_pixel(12'($urandom), 12'($urandom));
    endtask

    initial begin
        sh_disc = 13'd2048;
        sh_lon_off = '0;
        sh_width = 14'd2048;
        sh_height = 13'd1024;
        sh_south = 1'b0;
        sh_mirror = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_special_cases();
        test_random_sweep(34, 67, 560);
        test_random_sweep(67, 34, 560);
        test_random_sweep(0, 0, 400);
        test_backpressure();
        drain_results();
        if (remap_expected.size() != 0) error_count++;
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
